FILE: sv/rwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_pkg
// Shared field widths, codes and controller states of the restart walk block.
// ----------------------------------------------------------------------------
package rwr_pkg;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 6;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_LOAD_W  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_P0 = 2'd1;
    localparam logic [OP_W-1:0] OP_START   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RESTART  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NODES    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_HCAP,
        ST_SWEEP,
        ST_DRAIN,
        ST_MCLAMP,
        ST_MIX,
        ST_ROUND,
        ST_SQ,
        ST_NACC,
        ST_CHECK,
        ST_ORD,
        ST_OSEND
    } state_t;

endpackage

FILE: sv/rwr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_in_if
// Command channel: load items and start items.
// ----------------------------------------------------------------------------
interface rwr_in_if;
    logic                        valid;
    logic                        ready;
    logic [rwr_pkg::OP_W-1:0]    op;
    logic [rwr_pkg::IDX_W-1:0]   row;
    logic [rwr_pkg::IDX_W-1:0]   col;
    logic [rwr_pkg::VALUE_W-1:0] value;

    modport source (output valid, op, row, col, value, input ready);
    modport sink   (input valid, op, row, col, value, output ready);
endinterface

FILE: sv/rwr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_out_if
// Result channel: one node probability per transfer.
// ----------------------------------------------------------------------------
interface rwr_out_if;
    logic                        valid;
    logic                        ready;
    logic [rwr_pkg::IDX_W-1:0]   node_index;
    logic [rwr_pkg::VALUE_W-1:0] probability;
    logic                        last;
    logic                        converged;

    modport source (output valid, node_index, probability, last, converged, input ready);
    modport sink   (input valid, node_index, probability, last, converged, output ready);
endinterface

FILE: sv/rwr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rwr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/random_walk_restart_power_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_walk_restart_power_iter
// Random walk with restart by fixed-point power iteration over on-chip RAMs.
// ----------------------------------------------------------------------------
// Load items (weight or restart entry) write straight into the weight RAM
// or the restart RAM. A start item runs the iteration: each update walks
// node rows one at a time, and each row reads the weight RAM and the
// old-probability RAM once per column, then runs a short mix, round and
// squared-difference tail. Probabilities ping-pong between two RAMs. After
// the last update, each result passes through the ORD and OSEND states and
// transfers while the sink is ready. No new item is taken until the last
// result has transferred.
module random_walk_restart_power_iter #(
    parameter int MAX_NODES = 64,
    parameter int PROB_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rwr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rwr_pkg::CFG_W-1:0]     cfg_data,
    rwr_in_if.sink                        req,
    rwr_out_if.source                     rsp
);
    localparam int PW  = PROB_BITS;
    localparam int FB  = PROB_BITS - 1;
    localparam int AW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int WAW = $clog2(MAX_NODES * MAX_NODES);
    localparam int SW  = 2 * PW + 2;

    localparam logic [PW-1:0] ONE      = PW'(1) << FB;
    localparam logic [SW-1:0] HALF_S   = SW'(1) << (FB - 1);
    localparam logic [SW-1:0] ACC_CAP  = SW'(1) << (2 * FB);

    rwr_pkg::state_t state_reg, state_next;

    logic [15:0] restart_reg;
    logic [31:0] thresh_reg;
    logic [15:0] max_iter_reg;
    logic [6:0]  nodes_reg;

    logic [CW-1:0]     n_reg;
    logic [PW-1:0]     r_reg;
    logic [CW-1:0]     i_reg;
    logic [CW-1:0]     j_reg;
    logic [16:0]       iter_reg;
    logic              first_reg;
    logic              bank_reg;
    logic              conv_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic [PW-1:0]     p0i_reg;
    logic [PW-1:0]     oldi_reg;
    logic [2*PW-1:0]   prod_reg;
    logic [2*PW-2:0]   acc_reg;
    logic [PW-1:0]     m_reg;
    logic [2*PW-1:0]   mul_a_reg;
    logic [2*PW-1:0]   mul_b_reg;
    logic [PW-1:0]     d_reg;
    logic [2*PW-1:0]   sq_reg;
    logic [63:0]       norm_reg;

    logic [WAW-1:0] w_waddr, w_raddr;
    logic [AW-1:0]  p_raddr;
    logic           w_we, p0_we, pm0_we, pm1_we;
    logic [PW-1:0]  load_val;
    logic [PW-1:0]  w_rd, p0_rd, pm0_rd, pm1_rd, pbank_rd, pold_rd;
    logic           accept;
    logic           row_ok, col_ok;
    logic [PW-1:0]  t_val;
    logic [CW-1:0]  n_start;

    logic [SW-1:0]  acc_sum, m_full, t_sum, t_full;
    logic [64:0]    norm_sum;

    assign accept   = req.valid && req.ready;
    assign row_ok   = 32'(req.row) < 32'(MAX_NODES);
    assign col_ok   = 32'(req.col) < 32'(MAX_NODES);
    assign load_val = PW'(req.value);
    assign w_waddr  = WAW'(req.row[AW-1:0]) * WAW'(MAX_NODES) + WAW'(req.col[AW-1:0]);
    assign w_raddr  = WAW'(i_reg[AW-1:0]) * WAW'(MAX_NODES) + WAW'(j_reg[AW-1:0]);
    assign p_raddr  = (state_reg == rwr_pkg::ST_HEAD) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign pbank_rd = bank_reg ? pm1_rd : pm0_rd;
    assign pold_rd  = first_reg ? p0_rd : pbank_rd;

    assign acc_sum  = SW'(acc_reg) + SW'(prod_reg);
    assign m_full   = (SW'(acc_reg) + HALF_S) >> FB;
    assign t_sum    = SW'(mul_a_reg) + SW'(mul_b_reg) + HALF_S;
    assign t_full   = t_sum >> FB;
    assign t_val    = (t_full > SW'(ONE)) ? ONE : t_full[PW-1:0];
    assign norm_sum = 65'(norm_reg) + 65'(sq_reg);

    always_comb
    begin
        if (nodes_reg == 7'd0)
        begin
            n_start = CW'(1);
        end
        else if (32'(nodes_reg) > 32'(MAX_NODES))
        begin
            n_start = CW'(MAX_NODES);
        end
        else
        begin
            n_start = CW'(nodes_reg);
        end
    end

    rwr_ram #(.WIDTH(PW), .DEPTH(MAX_NODES * MAX_NODES)) u_weight (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(load_val),
        .raddr(w_raddr), .rdata(w_rd)
    );

    rwr_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_restart (
        .clk(clk), .we(p0_we), .waddr(req.row[AW-1:0]), .wdata(load_val),
        .raddr(p_raddr), .rdata(p0_rd)
    );

    rwr_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_prob0 (
        .clk(clk), .we(pm0_we), .waddr(i_reg[AW-1:0]), .wdata(t_val),
        .raddr(p_raddr), .rdata(pm0_rd)
    );

    rwr_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_prob1 (
        .clk(clk), .we(pm1_we), .waddr(i_reg[AW-1:0]), .wdata(t_val),
        .raddr(p_raddr), .rdata(pm1_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rwr_pkg::ST_IDLE:
            begin
                if (accept && req.op == rwr_pkg::OP_START)
                begin
                    state_next = rwr_pkg::ST_HEAD;
                end
            end
            rwr_pkg::ST_HEAD:   state_next = rwr_pkg::ST_HCAP;
            rwr_pkg::ST_HCAP:   state_next = rwr_pkg::ST_SWEEP;
            rwr_pkg::ST_SWEEP:
            begin
                if (j_reg == n_reg - CW'(1))
                begin
                    state_next = rwr_pkg::ST_DRAIN;
                end
            end
            rwr_pkg::ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = rwr_pkg::ST_MCLAMP;
                end
            end
            rwr_pkg::ST_MCLAMP: state_next = rwr_pkg::ST_MIX;
            rwr_pkg::ST_MIX:    state_next = rwr_pkg::ST_ROUND;
            rwr_pkg::ST_ROUND:  state_next = rwr_pkg::ST_SQ;
            rwr_pkg::ST_SQ:     state_next = rwr_pkg::ST_NACC;
            rwr_pkg::ST_NACC:
            begin
                state_next = (i_reg == n_reg - CW'(1)) ? rwr_pkg::ST_CHECK : rwr_pkg::ST_HEAD;
            end
            rwr_pkg::ST_CHECK:
            begin
                if (norm_reg <= 64'(thresh_reg) || iter_reg >= 17'(max_iter_reg))
                begin
                    state_next = rwr_pkg::ST_ORD;
                end
                else
                begin
                    state_next = rwr_pkg::ST_HEAD;
                end
            end
            rwr_pkg::ST_ORD:    state_next = rwr_pkg::ST_OSEND;
            rwr_pkg::ST_OSEND:
            begin
                if (rsp.ready)
                begin
                    state_next = (j_reg == n_reg - CW'(1)) ? rwr_pkg::ST_IDLE : rwr_pkg::ST_ORD;
                end
            end
            default:            state_next = rwr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready       = 1'b0;
        rsp.valid       = 1'b0;
        w_we            = 1'b0;
        p0_we           = 1'b0;
        pm0_we          = 1'b0;
        pm1_we          = 1'b0;
        rsp.node_index  = rwr_pkg::IDX_W'(j_reg);
        rsp.probability = rwr_pkg::VALUE_W'(pbank_rd);
        rsp.last        = (j_reg == n_reg - CW'(1));
        rsp.converged   = conv_reg;
        unique case (state_reg)
            rwr_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                w_we      = accept && req.op == rwr_pkg::OP_LOAD_W && row_ok && col_ok;
                p0_we     = accept && req.op == rwr_pkg::OP_LOAD_P0 && row_ok;
            end
            rwr_pkg::ST_ROUND:
            begin
                pm0_we = bank_reg;
                pm1_we = !bank_reg;
            end
            rwr_pkg::ST_OSEND:
            begin
                rsp.valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rwr_pkg::ST_IDLE;
            restart_reg  <= 16'd4096;
            thresh_reg   <= 32'd1024;
            max_iter_reg <= 16'd10000;
            nodes_reg    <= 7'd64;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            iter_reg     <= '0;
            first_reg    <= 1'b1;
            bank_reg     <= 1'b0;
            conv_reg     <= 1'b0;
            n_reg        <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == rwr_pkg::ST_SWEEP);
            v2_reg    <= v1_reg;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    rwr_pkg::REG_RESTART:  restart_reg  <= cfg_data[15:0];
                    rwr_pkg::REG_THRESH:   thresh_reg   <= cfg_data;
                    rwr_pkg::REG_MAX_ITER: max_iter_reg <= cfg_data[15:0];
                    rwr_pkg::REG_NODES:    nodes_reg    <= cfg_data[6:0];
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                rwr_pkg::ST_IDLE:
                begin
                    n_reg     <= n_start;
                    i_reg     <= '0;
                    iter_reg  <= '0;
                    first_reg <= 1'b1;
                end
                rwr_pkg::ST_HCAP:  j_reg <= '0;
                rwr_pkg::ST_SWEEP: j_reg <= j_reg + CW'(1);
                rwr_pkg::ST_NACC:
                begin
                    if (i_reg != n_reg - CW'(1))
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                rwr_pkg::ST_CHECK:
                begin
                    bank_reg  <= !bank_reg;
                    first_reg <= 1'b0;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    iter_reg  <= iter_reg + 17'd1;
                    conv_reg  <= (norm_reg <= 64'(thresh_reg));
                end
                rwr_pkg::ST_OSEND:
                begin
                    if (rsp.ready)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == rwr_pkg::ST_IDLE)
        begin
            r_reg    <= (32'(restart_reg) > 32'(ONE)) ? ONE : PW'(restart_reg);
            norm_reg <= '0;
        end
        if (state_reg == rwr_pkg::ST_HCAP)
        begin
            p0i_reg  <= p0_rd;
            oldi_reg <= pold_rd;
            acc_reg  <= '0;
        end
        if (v1_reg)
        begin
            prod_reg <= w_rd * pold_rd;
        end
        if (v2_reg)
        begin
            acc_reg <= (acc_sum >= ACC_CAP) ? ACC_CAP[2*PW-2:0] : acc_sum[2*PW-2:0];
        end
        if (state_reg == rwr_pkg::ST_MCLAMP)
        begin
            m_reg <= (m_full > SW'(ONE)) ? ONE : m_full[PW-1:0];
        end
        if (state_reg == rwr_pkg::ST_MIX)
        begin
            mul_a_reg <= (ONE - r_reg) * m_reg;
            mul_b_reg <= r_reg * p0i_reg;
        end
        if (state_reg == rwr_pkg::ST_ROUND)
        begin
            d_reg <= (t_val >= oldi_reg) ? t_val - oldi_reg : oldi_reg - t_val;
        end
        if (state_reg == rwr_pkg::ST_SQ)
        begin
            sq_reg <= d_reg * d_reg;
        end
        if (state_reg == rwr_pkg::ST_NACC)
        begin
            norm_reg <= norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
        end
        if (state_reg == rwr_pkg::ST_CHECK)
        begin
            norm_reg <= '0;
        end
    end
endmodule

FILE: test/random_walk_restart_power_iter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_walk_restart_power_iter_tb
// Self-checking bench for the restart walk power iteration block. A queue of
// load, start and noise items feeds a clocked driver; a clocked monitor checks
// every node result against an in-bench fixed-point iteration predictor.
// Phases change the registers while idle, cover the extremes and a long
// receiver hold-off that backs up the command channel.
// ----------------------------------------------------------------------------
module random_walk_restart_power_iter_tb;

    localparam logic [rwr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              NODES_MAX = 64;
    localparam longint unsigned ONE_Q     = 64'd32768;
    localparam longint unsigned HALF_Q    = 64'd16384;
    localparam longint unsigned ACC_CAP   = 64'd1 << 30;

    typedef struct packed {
        logic [rwr_pkg::OP_W-1:0]    op;
        logic [rwr_pkg::IDX_W-1:0]   row;
        logic [rwr_pkg::IDX_W-1:0]   col;
        logic [rwr_pkg::VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [rwr_pkg::IDX_W-1:0]   node;
        logic [rwr_pkg::VALUE_W-1:0] prob;
        logic                        last;
        logic                        conv;
    } node_prob_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we;
    logic [rwr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rwr_pkg::CFG_W-1:0]     cfg_data;

    rwr_in_if  req_if ();
    rwr_out_if rsp_if ();

    random_walk_restart_power_iter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if.sink),
        .rsp       (rsp_if.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state and register copies
    logic [15:0] w_mem [NODES_MAX][NODES_MAX];
    logic [15:0] p0_mem [NODES_MAX];
    logic [15:0] p_cur [NODES_MAX];
    logic [15:0] p_prev [NODES_MAX];
    logic [15:0] r_reg = 16'd4096;
    logic [31:0] thr_reg = 32'd1024;
    logic [15:0] iter_reg = 16'd10000;
    logic [6:0]  nodes_reg = 7'd64;

    bit          w_written [NODES_MAX][NODES_MAX];
    bit          p0_written [NODES_MAX];

    cmd_t        pending_cmds [$];
    node_prob_t  expected_probs [$];
    cmd_t        held;

    int          gap_left;
    int          stall_left;
    int          hold_left;
    bit          hold_done;
    bit          pressure_arm;
    bit          calm;
    int          errors;
    int          mismatches;
    int          checked;
    int          n_loads;
    int          n_starts;
    int          n_conv;
    int          queued;

    function automatic int used_nodes();
        if (nodes_reg == 0)
            return 1;
        if (nodes_reg > NODES_MAX)
            return NODES_MAX;
        return nodes_reg;
    endfunction

    task automatic walk_to_rest();
        int              n;
        int              iters;
        bit              conv;
        longint unsigned r;
        longint unsigned acc;
        longint unsigned prod;
        longint unsigned m;
        longint unsigned t;
        longint unsigned d;
        longint unsigned norm;
        node_prob_t      e;
        n = used_nodes();
        r = (r_reg > ONE_Q) ? ONE_Q : r_reg;
        conv = 1'b0;
        iters = 0;
        for (int i = 0; i < n; i++)
            p_cur[i] = p0_mem[i];
        while (1)
        begin
            for (int i = 0; i < n; i++)
                p_prev[i] = p_cur[i];
            norm = 0;
            for (int i = 0; i < n; i++)
            begin
                acc = 0;
                for (int j = 0; j < n; j++)
                begin
                    prod = longint'(w_mem[i][j]) * longint'(p_prev[j]);
                    if (acc >= ACC_CAP || prod >= ACC_CAP - acc)
                        acc = ACC_CAP;
                    else
                        acc = acc + prod;
                end
                m = (acc + HALF_Q) >> 15;
                if (m > ONE_Q)
                    m = ONE_Q;
                t = (ONE_Q - r) * m + r * longint'(p0_mem[i]);
                t = (t + HALF_Q) >> 15;
                if (t > ONE_Q)
                    t = ONE_Q;
                p_cur[i] = t[15:0];
                d = (t >= p_prev[i]) ? t - p_prev[i] : p_prev[i] - t;
                norm = norm + d * d;
            end
            if (norm <= thr_reg)
            begin
                conv = 1'b1;
                break;
            end
            if (iters >= iter_reg)
                break;
            iters++;
        end
        n_starts++;
        if (conv)
            n_conv++;
        for (int i = 0; i < n; i++)
        begin
            e.node = i[5:0];
            e.prob = p_cur[i];
            e.last = (i == n - 1);
            e.conv = conv;
            expected_probs.push_back(e);
        end
    endtask

    task automatic apply_cmd(cmd_t c);
        case (c.op)
            rwr_pkg::OP_LOAD_W:
            begin
                w_mem[c.row][c.col] = c.value;
                n_loads++;
            end
            rwr_pkg::OP_LOAD_P0:
            begin
                p0_mem[c.row] = c.value;
                n_loads++;
            end
            rwr_pkg::OP_START:
                walk_to_rest();
            default:
                ;
        endcase
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (req_if.valid)
                apply_cmd(held);
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req_if.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                held = pending_cmds.pop_front();
                req_if.valid <= 1'b1;
                req_if.op <= held.op;
                req_if.row <= held.row;
                req_if.col <= held.col;
                req_if.value <= held.value;
                if (!calm && $urandom_range(0, 6) == 0)
                    gap_left <= $urandom_range(1, 8);
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted in cycles
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (pressure_arm && !hold_done && rsp_if.valid)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        node_prob_t e;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_probs.size() == 0)
                begin
                    errors++;
                    $display("unexpected result node %0d prob %0d", rsp_if.node_index,
                             rsp_if.probability);
                end
                else
                begin
                    e = expected_probs.pop_front();
                    checked++;
                    if (rsp_if.node_index !== e.node || rsp_if.probability !== e.prob
                        || rsp_if.last !== e.last || rsp_if.converged !== e.conv)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp node %0d prob %0d last %0b conv %0b, ",
                                     e.node, e.prob, e.last, e.conv,
                                     "got node %0d prob %0d last %0b conv %0b",
                                     rsp_if.node_index, rsp_if.probability,
                                     rsp_if.last, rsp_if.converged);
                    end
                end
            end
            if (hold_left > 0 || (pressure_arm && !hold_done && rsp_if.valid))
                rsp_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall_left <= $urandom_range(1, 8);
            end
        end
    end

    task automatic queue_cmd(logic [rwr_pkg::OP_W-1:0] op, int row, int col, int value);
        cmd_t c;
        c.op = op;
        c.row = row[5:0];
        c.col = col[5:0];
        c.value = value[15:0];
        pending_cmds.push_back(c);
        queued++;
        if (op == rwr_pkg::OP_LOAD_W)
            w_written[row][col] = 1'b1;
        if (op == rwr_pkg::OP_LOAD_P0)
            p0_written[row] = 1'b1;
    endtask

    function automatic int rand_value(int n);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return $urandom_range(32769, 65535);
        if (k == 1)
            return 0;
        if (k == 2)
            return 32768;
        return $urandom_range(0, 65536 / n);
    endfunction

    // every entry a start of n nodes will read gets written first
    task automatic fill_unwritten(int n);
        for (int j = 0; j < n; j++)
            for (int i = 0; i < n; i++)
                if (!w_written[i][j])
                    queue_cmd(rwr_pkg::OP_LOAD_W, i, j, 32768 / n);
        for (int i = 0; i < n; i++)
            if (!p0_written[i])
                queue_cmd(rwr_pkg::OP_LOAD_P0, i, 0, 32768 / n);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || req_if.valid || expected_probs.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [rwr_pkg::CFG_IDX_W-1:0] idx,
                             logic [rwr_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            rwr_pkg::REG_RESTART:  r_reg = data[15:0];
            rwr_pkg::REG_THRESH:   thr_reg = data;
            rwr_pkg::REG_MAX_ITER: iter_reg = data[15:0];
            rwr_pkg::REG_NODES:    nodes_reg = data[6:0];
            default:      ;
        endcase
    endtask

    task automatic set_regs(int r, longint unsigned thr, int iters, int nodes);
        write_reg(rwr_pkg::REG_RESTART, r);
        write_reg(rwr_pkg::REG_THRESH, thr[31:0]);
        write_reg(rwr_pkg::REG_MAX_ITER, iters);
        write_reg(rwr_pkg::REG_NODES, nodes);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int len);
        int n;
        int k;
        n = used_nodes();
        fill_unwritten(n);
        for (int i = 0; i < len; i++)
        begin
            k = $urandom_range(0, 9);
            if (k <= 5)
                queue_cmd(rwr_pkg::OP_LOAD_W, $urandom_range(0, n - 1),
                          $urandom_range(0, n - 1), rand_value(n));
            else if (k == 6)
                queue_cmd(rwr_pkg::OP_LOAD_W, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 65535));
            else if (k == 7)
                queue_cmd(rwr_pkg::OP_LOAD_P0, $urandom_range(0, 63), $urandom_range(0, 63),
                          rand_value(n));
            else if (k == 8)
                queue_cmd(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 65535));
            else
                queue_cmd(rwr_pkg::OP_START, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom_range(0, 65535));
        end
        queue_cmd(rwr_pkg::OP_START, 0, 0, 0);
    endtask

    initial
    begin
        int r;
        longint unsigned thr;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.op = '0;
        req_if.row = '0;
        req_if.col = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        pressure_arm = 1'b0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of fields, noise op, ignored start fields
        set_regs(4096, 1024, 20, 4);
        queue_cmd(rwr_pkg::OP_LOAD_W, 63, 63, 65535);
        queue_cmd(rwr_pkg::OP_LOAD_W, 0, 63, 0);
        queue_cmd(rwr_pkg::OP_LOAD_P0, 63, 0, 32768);
        queue_cmd(OP_UNUSED, 63, 63, 65535);
        queue_cmd(OP_UNUSED, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            queue_cmd(rwr_pkg::OP_LOAD_P0, i, 0, (i == 0) ? 32768 : 0);
        fill_unwritten(4);
        queue_cmd(rwr_pkg::OP_START, 63, 63, 65535);
        queue_cmd(rwr_pkg::OP_LOAD_W, 1, 2, 65535);
        queue_cmd(rwr_pkg::OP_START, 0, 0, 0);
        wait_idle();

        // full restart, longest limit: settles on the second update, once the over-range restart entry is clamped
        set_regs(32768, 0, 65535, 3);
        queue_cmd(rwr_pkg::OP_LOAD_P0, 2, 0, 65535);
        queue_cmd(rwr_pkg::OP_START, 0, 0, 0);
        wait_idle();

        // over-range restart and node count of zero
        set_regs(40000, 64'hFFFF_FFFF, 65535, 0);
        random_phase(6);
        wait_idle();

        set_regs(0, 0, 5, 2);
        random_phase(8);
        wait_idle();

        // receiver holds off while more items wait
        pressure_arm <= 1'b1;
        set_regs(4096, 4096, 10, 8);
        fill_unwritten(8);
        queue_cmd(rwr_pkg::OP_START, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            queue_cmd(rwr_pkg::OP_LOAD_W, $urandom_range(0, 7), $urandom_range(0, 7), 4096);
        queue_cmd(rwr_pkg::OP_START, 0, 0, 0);
        wait_idle();

        while (queued < 130)
        begin
            r = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(0, 32768);
            thr = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1 << 20);
            set_regs(r, thr, $urandom_range(0, 40), $urandom_range(1, 8));
            random_phase($urandom_range(8, 20));
            wait_idle();
        end

        calm <= 1'b1;
        set_regs(6554, 256, 30, 6);
        random_phase(12);
        wait_idle();
        repeat (50) @(posedge clk);

        $display("covered %0d loads and %0d starts (%0d converged, %0d at limit)",
                 n_loads, n_starts, n_conv, n_starts - n_conv);
        $display("checked %0d node results, %0d errors", checked, errors);
        if (errors == 0 && expected_probs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rwr_pkg.sv
sv/rwr_in_if.sv
sv/rwr_out_if.sv
sv/rwr_ram.sv
sv/random_walk_restart_power_iter.sv
test/random_walk_restart_power_iter_tb.sv
